### rtl/scd_pkg.sv
// Shared types, constants and character tables for the scan code decoder.
`default_nettype none

package scd_pkg;

    localparam int CODE_COUNT = 128;
    localparam int CODE_W     = $clog2(CODE_COUNT);
    localparam int SCAN_W     = 8;
    localparam int CHAR_W     = 7;
    localparam int CFG_IDX_W  = 2;

    localparam logic [SCAN_W-1:0] PAUSE_CODE = 8'hE1;
    localparam logic [CHAR_W-1:0] CASE_GAP   = 7'h20;   // 'a' - 'A'
    localparam logic [CHAR_W-1:0] CHAR_UC_A  = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 7'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LC_A  = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 7'h7A;

    localparam logic [CODE_W-1:0] CAPS_CODE_RST   = 7'd58;
    localparam logic [CODE_W-1:0] LSHIFT_CODE_RST = 7'd42;
    localparam logic [CODE_W-1:0] RSHIFT_CODE_RST = 7'd54;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPS   = 2'd0,
        CFG_LSHIFT = 2'd1,
        CFG_RSHIFT = 2'd2
    } t_cfg_idx;

    // decoded event class, exactly one bit set per word
    typedef struct packed {
        logic clr;
        logic pause;
        logic ignored;
        logic high_brk;
        logic make;
        logic brk;
    } t_evt_dec;

    // key state as it stands after the current word; last_char is taken before its own character
    typedef struct packed {
        logic              shift_down;
        logic              caps_on;
        logic [CHAR_W-1:0] last_char;
        logic [CODE_W-1:0] last_code;
    } t_key_view;

    typedef struct packed {
        logic [CHAR_W-1:0] ascii_char;
        logic              char_valid;
        logic [CHAR_W-1:0] last_char;
        logic [CODE_W-1:0] last_code;
        logic              caps_state;
        logic              pause_seen;
        logic              code_ignored;
    } t_result;

    function automatic logic [CHAR_W-1:0] plain_char(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            7'd1:    ch = 7'h1B;
            7'd2:    ch = 7'h31;
            7'd3:    ch = 7'h32;
            7'd4:    ch = 7'h33;
            7'd5:    ch = 7'h34;
            7'd6:    ch = 7'h35;
            7'd7:    ch = 7'h36;
            7'd8:    ch = 7'h37;
            7'd9:    ch = 7'h38;
            7'd10:   ch = 7'h39;
            7'd11:   ch = 7'h30;
            7'd12:   ch = 7'h2D;
            7'd13:   ch = 7'h3D;
            7'd14:   ch = 7'h08;
            7'd15:   ch = 7'h09;
            7'd16:   ch = 7'h71;
            7'd17:   ch = 7'h77;
            7'd18:   ch = 7'h65;
            7'd19:   ch = 7'h72;
            7'd20:   ch = 7'h74;
            7'd21:   ch = 7'h79;
            7'd22:   ch = 7'h75;
            7'd23:   ch = 7'h69;
            7'd24:   ch = 7'h6F;
            7'd25:   ch = 7'h70;
            7'd26:   ch = 7'h5B;
            7'd27:   ch = 7'h5D;
            7'd28:   ch = 7'h0D;
            7'd30:   ch = 7'h61;
            7'd31:   ch = 7'h73;
            7'd32:   ch = 7'h64;
            7'd33:   ch = 7'h66;
            7'd34:   ch = 7'h67;
            7'd35:   ch = 7'h68;
            7'd36:   ch = 7'h6A;
            7'd37:   ch = 7'h6B;
            7'd38:   ch = 7'h6C;
            7'd39:   ch = 7'h3B;
            7'd40:   ch = 7'h27;
            7'd41:   ch = 7'h60;
            7'd43:   ch = 7'h5C;
            7'd44:   ch = 7'h7A;
            7'd45:   ch = 7'h78;
            7'd46:   ch = 7'h63;
            7'd47:   ch = 7'h76;
            7'd48:   ch = 7'h62;
            7'd49:   ch = 7'h6E;
            7'd50:   ch = 7'h6D;
            7'd51:   ch = 7'h2C;
            7'd52:   ch = 7'h2E;
            7'd53:   ch = 7'h2F;
            7'd55:   ch = 7'h2A;
            7'd57:   ch = 7'h20;
            7'd71:   ch = 7'h37;
            7'd72:   ch = 7'h38;
            7'd73:   ch = 7'h39;
            7'd74:   ch = 7'h2D;
            7'd75:   ch = 7'h34;
            7'd76:   ch = 7'h35;
            7'd77:   ch = 7'h36;
            7'd78:   ch = 7'h2B;
            7'd79:   ch = 7'h31;
            7'd80:   ch = 7'h32;
            7'd81:   ch = 7'h33;
            7'd82:   ch = 7'h30;
            7'd83:   ch = 7'h7F;
            default: ch = '0;
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] shift_char(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            7'd1:    ch = 7'h1B;
            7'd2:    ch = 7'h21;
            7'd3:    ch = 7'h40;
            7'd4:    ch = 7'h23;
            7'd5:    ch = 7'h24;
            7'd6:    ch = 7'h25;
            7'd7:    ch = 7'h5E;
            7'd8:    ch = 7'h26;
            7'd9:    ch = 7'h2A;
            7'd10:   ch = 7'h28;
            7'd11:   ch = 7'h29;
            7'd12:   ch = 7'h5F;
            7'd13:   ch = 7'h2B;
            7'd14:   ch = 7'h08;
            7'd15:   ch = 7'h09;
            7'd16:   ch = 7'h51;
            7'd17:   ch = 7'h57;
            7'd18:   ch = 7'h45;
            7'd19:   ch = 7'h52;
            7'd20:   ch = 7'h54;
            7'd21:   ch = 7'h59;
            7'd22:   ch = 7'h55;
            7'd23:   ch = 7'h49;
            7'd24:   ch = 7'h4F;
            7'd25:   ch = 7'h50;
            7'd26:   ch = 7'h7B;
            7'd27:   ch = 7'h7D;
            7'd28:   ch = 7'h0D;
            7'd30:   ch = 7'h41;
            7'd31:   ch = 7'h53;
            7'd32:   ch = 7'h44;
            7'd33:   ch = 7'h46;
            7'd34:   ch = 7'h47;
            7'd35:   ch = 7'h48;
            7'd36:   ch = 7'h4A;
            7'd37:   ch = 7'h4B;
            7'd38:   ch = 7'h4C;
            7'd39:   ch = 7'h3A;
            7'd40:   ch = 7'h22;
            7'd41:   ch = 7'h7E;
            7'd43:   ch = 7'h7C;
            7'd44:   ch = 7'h5A;
            7'd45:   ch = 7'h58;
            7'd46:   ch = 7'h43;
            7'd47:   ch = 7'h56;
            7'd48:   ch = 7'h42;
            7'd49:   ch = 7'h4E;
            7'd50:   ch = 7'h4D;
            7'd51:   ch = 7'h3C;
            7'd52:   ch = 7'h3E;
            7'd53:   ch = 7'h3F;
            7'd55:   ch = 7'h2A;
            7'd57:   ch = 7'h20;
            7'd71:   ch = 7'h37;
            7'd72:   ch = 7'h38;
            7'd73:   ch = 7'h39;
            7'd74:   ch = 7'h2D;
            7'd75:   ch = 7'h34;
            7'd76:   ch = 7'h35;
            7'd77:   ch = 7'h36;
            7'd78:   ch = 7'h2B;
            7'd79:   ch = 7'h31;
            7'd80:   ch = 7'h32;
            7'd81:   ch = 7'h33;
            7'd82:   ch = 7'h30;
            7'd83:   ch = 7'h7F;
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

### rtl/scd_in_if.sv
// Keyboard event channel: valid/ready plus event word.
`default_nettype none

interface scd_in_if
    import scd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              func;
    logic [SCAN_W-1:0] scan_code;
    logic              pressed;

    modport source (output valid, output func, output scan_code, output pressed,
                    input ready);
    modport sink   (input valid, input func, input scan_code, input pressed,
                    output ready);
endinterface

`default_nettype wire

### rtl/scd_out_if.sv
// Decoder result channel: valid/ready plus result word.
`default_nettype none

interface scd_out_if
    import scd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ascii_char;
    logic              char_valid;
    logic [CHAR_W-1:0] last_char;
    logic [CODE_W-1:0] last_code;
    logic              caps_state;
    logic              pause_seen;
    logic              code_ignored;

    modport source (output valid, output ascii_char, output char_valid,
                    output last_char, output last_code, output caps_state,
                    output pause_seen, output code_ignored, input ready);
    modport sink   (input valid, input ascii_char, input char_valid,
                    input last_char, input last_code, input caps_state,
                    input pause_seen, input code_ignored, output ready);
endinterface

`default_nettype wire

### rtl/scd_charmap.sv
// Scan code to character lookup with shift select and caps lock case swap.
`default_nettype none

module scd_charmap
    import scd_pkg::*;
(
    input  wire logic [CODE_W-1:0] i_code,
    input  wire logic              i_shift_down,
    input  wire logic              i_caps_on,
    output logic      [CHAR_W-1:0] o_char
);

    logic [CHAR_W-1:0] plain_ch;
    logic [CHAR_W-1:0] shift_ch;
    logic              plain_lc;
    logic              shift_uc;

    assign plain_ch = plain_char(i_code);
    assign shift_ch = shift_char(i_code);
    assign plain_lc = (plain_ch >= CHAR_LC_A) && (plain_ch <= CHAR_LC_Z);
    assign shift_uc = (shift_ch >= CHAR_UC_A) && (shift_ch <= CHAR_UC_Z);

    always_comb begin
        if (i_shift_down) begin
            o_char = (shift_uc && i_caps_on) ? shift_ch + CASE_GAP : shift_ch;
        end else begin
            o_char = (plain_lc && i_caps_on) ? plain_ch - CASE_GAP : plain_ch;
        end
    end

endmodule

`default_nettype wire

### rtl/scd_keymap.sv
// Key-down bitmap, caps lock, last code/char and the key code registers.
`default_nettype none

module scd_keymap
    import scd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CODE_W-1:0]    i_cfg_data,
    input  wire logic                 i_accept,
    input  wire t_evt_dec             i_dec,
    input  wire logic [CODE_W-1:0]    i_code,
    input  wire logic [CHAR_W-1:0]    i_char,
    output t_key_view                 o_view
);

    logic [CODE_COUNT-1:0] r_map;
    logic [CODE_COUNT-1:0] n_map;
    logic                  r_caps;
    logic                  n_caps;
    logic [CHAR_W-1:0]     r_last_char;
    logic [CHAR_W-1:0]     n_last_char;
    logic [CHAR_W-1:0]     base_char;
    logic [CODE_W-1:0]     r_last_code;
    logic [CODE_W-1:0]     n_last_code;
    logic [CODE_W-1:0]     r_caps_code;
    logic [CODE_W-1:0]     r_lshift_code;
    logic [CODE_W-1:0]     r_rshift_code;

    always_comb begin
        n_map       = r_map;
        n_caps      = r_caps;
        n_last_code = r_last_code;
        if (i_dec.clr) begin
            n_map       = '0;
            n_last_code = '0;
        end else if (i_dec.brk) begin
            n_map[i_code] = 1'b0;
        end else if (i_dec.make) begin
            n_map[i_code] = 1'b1;
            n_last_code   = i_code;
            if (i_code == r_caps_code) begin
                n_caps = ~r_caps;
            end
        end
    end

    // last char before this word's own character; kept off the lookup path
    assign base_char   = i_dec.clr ? '0 : r_last_char;
    assign n_last_char = (i_dec.make && (i_char != '0)) ? i_char : base_char;

    // shift lookup sees this word's own make
    assign o_view.shift_down = n_map[r_lshift_code] | n_map[r_rshift_code];
    assign o_view.caps_on    = n_caps;
    assign o_view.last_char  = base_char;
    assign o_view.last_code  = n_last_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map       <= '0;
            r_caps      <= 1'b0;
            r_last_char <= '0;
            r_last_code <= '0;
        end else if (i_accept) begin
            r_map       <= n_map;
            r_caps      <= n_caps;
            r_last_char <= n_last_char;
            r_last_code <= n_last_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caps_code   <= CAPS_CODE_RST;
            r_lshift_code <= LSHIFT_CODE_RST;
            r_rshift_code <= RSHIFT_CODE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CAPS:   r_caps_code   <= i_cfg_data;
                CFG_LSHIFT: r_lshift_code <= i_cfg_data;
                CFG_RSHIFT: r_rshift_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/scan_code_to_ascii_decoder.sv
// Top level: event decode, key state, character lookup and result register.
// Output: the result is registered and appears in the cycle after its event word is accepted.
// Throughput: one word per cycle when output ready is high; input ready follows
//   it: the single result register is refilled in the same cycle it is drained.
// Reset (synchronous, active low): key map, caps lock, last char and last
//   code clear; key code registers return to 58 / 42 / 54; no result pending.
`default_nettype none

module scan_code_to_ascii_decoder
    import scd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CODE_W-1:0]    i_cfg_data,
    scd_in_if.sink                    i_evt,
    scd_out_if.source                 o_res
);

    t_evt_dec          dec;
    t_key_view         view;
    logic              accept;
    logic              low_code;
    logic [CODE_W-1:0] code;
    logic [CHAR_W-1:0] map_ch;
    logic [CHAR_W-1:0] evt_ch;
    t_result           n_res;
    t_result           r_res;
    logic              r_valid;

    // result slot is free when empty or being taken this cycle
    assign i_evt.ready = ~r_valid | o_res.ready;
    assign accept      = i_evt.valid & i_evt.ready;

    // event classes; 0xE1 wins over the high-code range
    assign code     = i_evt.scan_code[CODE_W-1:0];
    assign low_code = (i_evt.scan_code[SCAN_W-1:CODE_W] == '0);

    always_comb begin
        dec          = '0;
        dec.clr      = i_evt.func;
        dec.pause    = ~i_evt.func & (i_evt.scan_code == PAUSE_CODE);
        dec.ignored  = ~i_evt.func & ~dec.pause & ~low_code & i_evt.pressed;
        dec.high_brk = ~i_evt.func & ~dec.pause & ~low_code & ~i_evt.pressed;
        dec.make     = ~i_evt.func & low_code & i_evt.pressed;
        dec.brk      = ~i_evt.func & low_code & ~i_evt.pressed;
    end

    scd_keymap u_keymap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_dec      (dec),
        .i_code     (code),
        .i_char     (evt_ch),
        .o_view     (view)
    );

    scd_charmap u_charmap (
        .i_code       (code),
        .i_shift_down (view.shift_down),
        .i_caps_on    (view.caps_on),
        .o_char       (map_ch)
    );

    // only a make produces a character
    assign evt_ch = dec.make ? map_ch : '0;

    always_comb begin
        n_res.ascii_char   = evt_ch;
        n_res.char_valid   = (evt_ch != '0);
        // a new character replaces the remembered one
        n_res.last_char    = (evt_ch != '0) ? evt_ch : view.last_char;
        n_res.last_code    = view.last_code;
        n_res.caps_state   = view.caps_on;
        n_res.pause_seen   = dec.pause;
        n_res.code_ignored = dec.ignored;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.ascii_char   = r_res.ascii_char;
    assign o_res.char_valid   = r_res.char_valid;
    assign o_res.last_char    = r_res.last_char;
    assign o_res.last_code    = r_res.last_code;
    assign o_res.caps_state   = r_res.caps_state;
    assign o_res.pause_seen   = r_res.pause_seen;
    assign o_res.code_ignored = r_res.code_ignored;

endmodule

`default_nettype wire
